// ===== rtl/ast_pkg.sv =====
package ast_pkg;

   localparam int PosBits = 32;
   localparam int FifoDepth = 4;
   localparam int FifoPtrBits = $clog2(FifoDepth);
   localparam int FifoCntBits = $clog2(FifoDepth + 1);

   localparam logic OpEnd = 1'b1;

   localparam logic [7:0] CharHash    = 8'h23;
   localparam logic [7:0] CharNewline = 8'h0A;
   localparam logic [7:0] CharColon   = 8'h3A;
   localparam logic [7:0] CharSemi    = 8'h3B;
   localparam logic [7:0] CharZero    = 8'h30;

   typedef logic [PosBits-1:0] pos_type;

   typedef enum logic [2:0] {
      ModeIdle,
      ModeComment,
      ModeIdent,
      ModeNumber,
      ModeDead
   } mode_type;

   typedef enum logic [2:0] {
      KindEof    = 3'd0,
      KindIdent  = 3'd1,
      KindNumber = 3'd2,
      KindColon  = 3'd3,
      KindSemi   = 3'd4,
      KindError  = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      ErrNone     = 2'd0,
      ErrBadChar  = 2'd1,
      ErrTooLarge = 2'd2
   } err_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] span_start;
      logic [31:0] span_end;
      logic [63:0] value;
      err_type     err;
      logic        last;
   } res_type;

   // Up to two results per request, always in slot order.
   typedef struct packed {
      logic    v0;
      res_type r0;
      logic    v1;
      res_type r1;
   } push_type;

   function automatic res_type make_res(input kind_type kind, input pos_type s,
                                        input pos_type e, input logic [63:0] v,
                                        input err_type er, input logic lst);
      res_type r;
      r.kind       = kind;
      r.span_start = 32'(s);
      r.span_end   = 32'(e);
      r.value      = v;
      r.err        = er;
      r.last       = lst;
      return r;
   endfunction

endpackage

// ===== rtl/ast_scan.sv =====
module ast_scan (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // char_byte
   input  logic [0:0]        req_tuser,   // op
   input  logic              room2,
   output ast_pkg::push_type push
);
   import ast_pkg::*;

   logic       item_valid_ff, item_valid_in;
   logic       op_ff;
   logic [7:0] char_ff;
   logic       accept, fire;

   mode_type    mode_ff, mode_in;
   pos_type     pos_ff, pos_in, begin_ff, begin_in, pos_next;
   logic [63:0] acc_ff, acc_in;
   logic [67:0] acc_times10;
   logic        overflow;
   logic [63:0] digit;

   logic    a_v, b_v, do_idle;
   res_type t_a, t_b;
   logic    is_alpha, is_digit, is_space;

   assign fire       = item_valid_ff && room2;
   assign req_tready = !item_valid_ff || room2;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (accept) begin
         item_valid_in = 1'b1;
      end else if (fire) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
      if (accept) begin
         op_ff   <= req_tuser[0];
         char_ff <= req_tdata;
      end
   end

   assign is_alpha = (char_ff inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h5F});
   assign is_digit = (char_ff inside {[8'h30:8'h39]});
   assign is_space = (char_ff inside {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C});

   assign pos_next    = pos_ff + pos_type'(1);
   assign digit       = 64'(char_ff - CharZero);
   // Ten times the value as two shifts, plus the new digit, in a word wide enough
   // to see any carry out of 64 bits.
   assign acc_times10 = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {4'b0000, digit};
   assign overflow    = |acc_times10[67:64];

   always_comb begin
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      begin_in = begin_ff;
      acc_in   = acc_ff;
      a_v      = 1'b0;
      b_v      = 1'b0;
      do_idle  = 1'b0;
      t_a      = make_res(KindIdent, begin_ff, pos_ff, 64'd0, ErrNone, 1'b0);
      t_b      = make_res(KindEof, pos_ff, pos_ff, 64'd0, ErrNone, 1'b1);

      if (op_ff == OpEnd) begin
         if (mode_ff != ModeDead) begin
            if (mode_ff == ModeIdent) begin
               a_v = 1'b1;
            end else if (mode_ff == ModeNumber) begin
               a_v = 1'b1;
               t_a = make_res(KindNumber, begin_ff, pos_ff, acc_ff, ErrNone, 1'b0);
            end
            b_v = 1'b1;
         end
         mode_in  = ModeIdle;
         pos_in   = '0;
         begin_in = '0;
         acc_in   = '0;
      end else begin
         case (mode_ff)
            ModeDead: begin
            end
            ModeComment: begin
               if (char_ff == CharNewline) begin
                  mode_in = ModeIdle;
               end
               pos_in = pos_next;
            end
            ModeIdent: begin
               if (is_alpha || is_digit) begin
                  pos_in = pos_next;
               end else begin
                  a_v     = 1'b1;
                  do_idle = 1'b1;
               end
            end
            ModeNumber: begin
               if (is_digit) begin
                  if (overflow) begin
                     b_v     = 1'b1;
                     t_b     = make_res(KindError, begin_ff, pos_next, 64'd0,
                                        ErrTooLarge, 1'b1);
                     mode_in = ModeDead;
                  end else begin
                     acc_in = acc_times10[63:0];
                     pos_in = pos_next;
                  end
               end else begin
                  a_v     = 1'b1;
                  t_a     = make_res(KindNumber, begin_ff, pos_ff, acc_ff, ErrNone, 1'b0);
                  do_idle = 1'b1;
               end
            end
            default: begin
               do_idle = 1'b1;
            end
         endcase

         if (do_idle) begin
            mode_in = ModeIdle;
            pos_in  = pos_next;
            if (is_space) begin
               mode_in = ModeIdle;
            end else if (char_ff == CharHash) begin
               mode_in = ModeComment;
            end else if (is_alpha) begin
               begin_in = pos_ff;
               mode_in  = ModeIdent;
            end else if (is_digit) begin
               begin_in = pos_ff;
               acc_in   = digit;
               mode_in  = ModeNumber;
            end else if (char_ff == CharColon) begin
               b_v = 1'b1;
               t_b = make_res(KindColon, pos_ff, pos_next, 64'd0, ErrNone, 1'b0);
            end else if (char_ff == CharSemi) begin
               b_v = 1'b1;
               t_b = make_res(KindSemi, pos_ff, pos_next, 64'd0, ErrNone, 1'b0);
            end else begin
               b_v     = 1'b1;
               t_b     = make_res(KindError, pos_ff, pos_next, 64'd0, ErrBadChar, 1'b1);
               mode_in = ModeDead;
            end
         end
      end
   end

   // A token that closes always goes out ahead of the one that the byte opens.
   always_comb begin
      push.v0 = fire && (a_v || b_v);
      push.r0 = a_v ? t_a : t_b;
      push.v1 = fire && a_v && b_v;
      push.r1 = t_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ModeIdle;
         pos_ff  <= '0;
      end else if (fire) begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
      end
      if (fire) begin
         begin_ff <= begin_in;
         acc_ff   <= acc_in;
      end
   end

   a_error_kills : assert property (@(posedge clock) disable iff (reset)
      push.v0 && push.r0.kind == KindError |=> mode_ff == ModeDead)
      else $error("scanner not dead after an error token");

   a_eof_restarts : assert property (@(posedge clock) disable iff (reset)
      fire && op_ff == OpEnd |=> pos_ff == '0 && mode_ff == ModeIdle)
      else $error("scanner not back at position zero after end of source");

endmodule

// ===== rtl/ast_rsp_fifo.sv =====
module ast_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  ast_pkg::push_type push,
   output logic              room2,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output ast_pkg::res_type  head
);
   import ast_pkg::*;

   res_type                mem [FifoDepth];
   logic [FifoPtrBits-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FifoCntBits-1:0] count_ff, count_in, push_n;
   logic                   pop;

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign room2      = (count_ff <= FifoCntBits'(FifoDepth - 2));
   assign head       = mem[rd_ptr_ff];
   assign push_n     = FifoCntBits'(push.v0) + FifoCntBits'(push.v1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FifoPtrBits'(push_n);
      rd_ptr_in = rd_ptr_ff + FifoPtrBits'(pop);
      count_in  = count_ff + push_n - FifoCntBits'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.v0) begin
         mem[wr_ptr_ff] <= push.r0;
      end
      if (push.v1) begin
         mem[wr_ptr_ff + FifoPtrBits'(1)] <= push.r1;
      end
   end

   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      push.v0 |-> count_ff <= FifoCntBits'(FifoDepth - 2))
      else $error("result queue written without room for two");

   a_slot_order : assert property (@(posedge clock) disable iff (reset)
      push.v1 |-> push.v0 && !push.r0.last)
      else $error("second result without a closing token ahead of it");

endmodule

// ===== rtl/assembler_source_tokenizer.sv =====
// Tokenizer for assembler source text. Each request carries one source byte
// (tuser 0) or the end of the source (tuser 1); results are tokens with kind,
// byte span, decimal value and error code, and tlast marks the EOF or error
// token that ends a stream. A request is registered, scanned once the queue
// has room for two results, and its results land in a four-entry result
// queue. One request is taken every cycle while the queue has room for two;
// a byte that both closes an identifier or number and makes a new token gives
// two results, which go out one by one, and the queue lets a short run of
// those pass at full input rate. Requests stall only while the queue has
// fewer than two free entries. After an error token all source bytes are
// dropped without result until the end request, which then gives no result.
// After EOF or that end request the next byte starts at position zero.
module assembler_source_tokenizer (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // char_byte [7:0]
   input  logic [0:0]   req_tuser,   // op [0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // span_start [31:0], span_end [63:32],
                                     // number_value [127:64], error_code [129:128]
   output logic [2:0]   rsp_tuser,   // token_kind [2:0]
   output logic         rsp_tlast    // last
);
   import ast_pkg::*;

   push_type push;
   res_type  head;
   logic     room2;

   ast_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .room2      (room2),
      .push       (push)
   );

   ast_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room2      (room2),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .head       (head)
   );

   assign rsp_tdata = {6'b000000, head.err, head.value, head.span_end, head.span_start};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule

// ===== dv/assembler_source_tokenizer_tb.sv =====
module assembler_source_tokenizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ast_pkg::*;

   localparam logic OpByte = ~OpEnd;
   localparam logic [63:0] ValueMax = '1;
   localparam logic [63:0] TenthOfMax = ValueMax / 64'd10;
   localparam int QuietLimit = 2000;
   localparam int DrainCycles = 20;

   typedef enum {SinkFree, SinkChoppy, SinkPattern, SinkBursty} sink_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;   // char_byte [7:0]
   logic [0:0]   req_tuser;   // op [0]
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [135:0] rsp_tdata;   // span_start [31:0], span_end [63:32],
                              // number_value [127:64], error_code [129:128]
   logic [2:0]   rsp_tuser;   // token_kind [2:0]
   logic         rsp_tlast;

   // Scanner state as the block should hold it.
   mode_type    scan_state;
   pos_type     scan_pos;
   pos_type     tok_start;
   logic [63:0] digit_value;

   res_type     expected_tokens[$];
   int          fail_count = 0;
   int          live_items = 0;
   int          quiet_cycles = 0;

   int          src_max_gap = 0;
   int          src_max_burst = 64;
   int          burst_left = 0;
   sink_type    sink_mode = SinkFree;
   int          stall_left = 0;
   logic [10:0] stall_pattern = 11'b101_1101_0110;

   assembler_source_tokenizer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic bit is_digit(input logic [7:0] ch);
      return ch >= "0" && ch <= "9";
   endfunction

   function automatic bit is_word_start(input logic [7:0] ch);
      return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") || ch == "_";
   endfunction

   function automatic bit is_blank(input logic [7:0] ch);
      return ch == 8'h20 || ch == 8'h09 || ch == CharNewline || ch == 8'h0D ||
             ch == 8'h0B || ch == 8'h0C;
   endfunction

   function automatic void clear_scanner();
      scan_state  = ModeIdle;
      scan_pos    = '0;
      tok_start   = '0;
      digit_value = '0;
   endfunction

   function automatic void push_token(input kind_type kind, input pos_type s, input pos_type e,
                                      input logic [63:0] v, input err_type er, input logic lst);
      res_type tok;
      tok.kind       = kind;
      tok.span_start = 32'(s);
      tok.span_end   = 32'(e);
      tok.value      = v;
      tok.err        = er;
      tok.last       = lst;
      expected_tokens.push_back(tok);
   endfunction

   // Works out the tokens that one accepted request gives and advances the scanner.
   function automatic void tokenize_request(input logic op, input logic [7:0] ch);
      pos_type     here;
      pos_type     after;
      logic [63:0] d;
      here  = scan_pos;
      after = scan_pos + 1'b1;
      if (op == OpEnd) begin
         if (scan_state == ModeDead) begin
            clear_scanner();
            return;
         end
         if (scan_state == ModeIdent)
            push_token(KindIdent, tok_start, here, '0, ErrNone, 1'b0);
         else if (scan_state == ModeNumber)
            push_token(KindNumber, tok_start, here, digit_value, ErrNone, 1'b0);
         push_token(KindEof, here, here, '0, ErrNone, 1'b1);
         clear_scanner();
         return;
      end
      case (scan_state)
         ModeDead: return;
         ModeComment: begin
            if (ch == CharNewline)
               scan_state = ModeIdle;
            scan_pos = after;
            return;
         end
         ModeIdent: begin
            if (is_word_start(ch) || is_digit(ch)) begin
               scan_pos = after;
               return;
            end
            push_token(KindIdent, tok_start, here, '0, ErrNone, 1'b0);
            scan_state = ModeIdle;
         end
         ModeNumber: begin
            if (is_digit(ch)) begin
               d = 64'(ch - CharZero);
               if (digit_value > (ValueMax - d) / 64'd10) begin
                  push_token(KindError, tok_start, after, '0, ErrTooLarge, 1'b1);
                  scan_state = ModeDead;
                  return;
               end
               digit_value = digit_value * 64'd10 + d;
               scan_pos = after;
               return;
            end
            push_token(KindNumber, tok_start, here, digit_value, ErrNone, 1'b0);
            scan_state = ModeIdle;
         end
         default: scan_state = ModeIdle;
      endcase

      // Between tokens: the byte is skipped as a blank, starts a comment or token, or is rejected.
      if (is_blank(ch)) begin
      end else if (ch == CharHash) begin
         scan_state = ModeComment;
      end else if (is_word_start(ch)) begin
         tok_start  = here;
         scan_state = ModeIdent;
      end else if (is_digit(ch)) begin
         tok_start   = here;
         digit_value = 64'(ch - CharZero);
         scan_state  = ModeNumber;
      end else if (ch == CharColon) begin
         push_token(KindColon, here, after, '0, ErrNone, 1'b0);
      end else if (ch == CharSemi) begin
         push_token(KindSemi, here, after, '0, ErrNone, 1'b0);
      end else begin
         push_token(KindError, here, after, '0, ErrBadChar, 1'b1);
         scan_state = ModeDead;
         return;
      end
      scan_pos = after;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      fail_count++;
      if (fail_count <= 50)
         $display("%0t ns: %s: got %0h, expected %0h", $realtime, what, got, want);
   endtask

   // Sends one request, in bursts of random length separated by random gaps.
   task automatic send_request(input logic op, input logic [7:0] ch);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, src_max_burst);
         gap = (src_max_gap == 0) ? 0 : $urandom_range(0, src_max_gap);
         repeat (gap) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= ch;
      do @(posedge clock); while (req_tready !== 1'b1);
      burst_left--;
      live_items++;
      tokenize_request(op, ch);
   endtask

   task automatic send_end();
      send_request(OpEnd, 8'($urandom));
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_request(OpByte, s[i]);
   endtask

   task automatic send_number(input logic [63:0] v);
      logic [7:0] digits[$];
      do begin
         digits.push_front(CharZero + 8'(v % 64'd10));
         v = v / 64'd10;
      end while (v != 0);
      foreach (digits[i])
         send_request(OpByte, digits[i]);
   endtask

   function automatic logic [7:0] word_char(input bit first);
      int r;
      r = $urandom_range(0, first ? 52 : 62);
      if (r < 26)
         return 8'("a" + r);
      else if (r < 52)
         return 8'("A" + r - 26);
      else if (r == 52)
         return "_";
      return 8'("0" + r - 53);
   endfunction

   function automatic logic [7:0] blank_char();
      case ($urandom_range(0, 5))
         0: return 8'h20;
         1: return 8'h09;
         2: return CharNewline;
         3: return 8'h0D;
         4: return 8'h0B;
         default: return 8'h0C;
      endcase
   endfunction

   function automatic logic [7:0] bad_char();
      logic [7:0] ch;
      do ch = 8'($urandom);
      while (is_blank(ch) || is_digit(ch) || is_word_start(ch) || ch == CharHash ||
             ch == CharColon || ch == CharSemi);
      return ch;
   endfunction

   // Numbers around the 64-bit limit or with leading zeros, sometimes with one digit more.
   task automatic send_big_number();
      logic [63:0] v;
      case ($urandom_range(0, 3))
         0: v = ValueMax - 64'($urandom_range(0, 9));
         1: v = TenthOfMax;
         2: v = {$urandom, $urandom};
         default: begin
            repeat ($urandom_range(1, 4)) send_request(OpByte, CharZero);
            v = 64'($urandom);
         end
      endcase
      send_number(v);
      if ($urandom_range(0, 1))
         send_request(OpByte, 8'(CharZero + $urandom_range(0, 9)));
   endtask

   // One source of random pieces: mostly well-formed tokens, some noise.
   task automatic send_random_source(input int max_pieces);
      int pieces;
      int pick;
      logic [7:0] ch;
      pieces = $urandom_range(1, max_pieces);
      for (int p = 0; p < pieces; p++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            send_request(OpByte, word_char(1'b1));
            repeat ($urandom_range(0, 6)) send_request(OpByte, word_char(1'b0));
         end else if (pick < 48) begin
            repeat ($urandom_range(1, 5))
               send_request(OpByte, 8'(CharZero + $urandom_range(0, 9)));
         end else if (pick < 52) begin
            send_big_number();
         end else if (pick < 62) begin
            send_request(OpByte, CharColon);
         end else if (pick < 70) begin
            send_request(OpByte, CharSemi);
         end else if (pick < 80) begin
            repeat ($urandom_range(1, 3)) send_request(OpByte, blank_char());
         end else if (pick < 92) begin
            send_request(OpByte, CharHash);
            repeat ($urandom_range(0, 6)) begin
               do ch = 8'($urandom);
               while (ch == CharNewline);
               send_request(OpByte, ch);
            end
            // An unterminated comment swallows the rest of the source.
            if ($urandom_range(0, 3) != 0)
               send_request(OpByte, CharNewline);
         end else if (pick < 97) begin
            send_request(OpByte, 8'($urandom));
         end else begin
            send_request(OpByte, bad_char());
            repeat ($urandom_range(0, 4)) send_request(OpByte, 8'($urandom));
         end
         if ($urandom_range(0, 1))
            send_request(OpByte, blank_char());
      end
      send_end();
   endtask

   task automatic run_random_sources(input int count);
      int target;
      target = live_items + count;
      while (live_items < target)
         send_random_source(16);
   endtask

   task automatic test_directed();
      src_max_gap = 0;
      sink_mode   = SinkFree;
      send_end();
      send_text("_a9:");
      send_text(" \t\r");
      send_request(OpByte, 8'h0B);
      send_request(OpByte, 8'h0C);
      send_text("Zz 7;");
      send_text("#c:\n");
      send_text("42");
      send_end();
      send_text("q#");
      send_end();
   endtask

   task automatic test_bad_bytes();
      src_max_gap   = 3;
      src_max_burst = 4;
      sink_mode     = SinkChoppy;
      send_request(OpByte, 8'h00);
      send_end();
      send_request(OpByte, 8'h80);
      send_end();
      send_request(OpByte, 8'hFF);
      send_end();
      send_text("ab$a;");
      send_end();
      send_text("12@");
      send_end();
   endtask

   task automatic test_number_limits();
      src_max_gap = 0;
      sink_mode   = SinkPattern;
      send_number(ValueMax);
      send_end();
      send_number(ValueMax);
      send_text("0x");
      send_end();
      send_number(TenthOfMax);
      send_text("5 ");
      send_number(TenthOfMax);
      send_text("6;");
      send_end();
      send_text("000000000000000000000000123:");
      send_end();
   endtask

   task automatic test_random_full_rate();
      src_max_gap   = 0;
      src_max_burst = 64;
      sink_mode     = SinkFree;
      run_random_sources(350);
   endtask

   task automatic test_random_idling();
      src_max_gap   = 8;
      src_max_burst = 12;
      sink_mode     = SinkPattern;
      run_random_sources(250);
      sink_mode     = SinkChoppy;
      run_random_sources(250);
   endtask

   task automatic test_random_backpressure();
      src_max_gap   = 0;
      src_max_burst = 64;
      sink_mode     = SinkBursty;
      run_random_sources(450);
   endtask

   always @(negedge clock) begin : drive_sink
      case (sink_mode)
         SinkFree: rsp_tready <= 1'b1;
         SinkChoppy: rsp_tready <= ($urandom_range(0, 3) != 0);
         SinkPattern: begin
            stall_pattern <= {stall_pattern[0], stall_pattern[10:1]};
            rsp_tready    <= stall_pattern[0];
         end
         default: begin
            if (stall_left > 0) begin
               stall_left <= stall_left - 1;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= 1'b1;
               if ($urandom_range(0, 15) == 0)
                  stall_left <= $urandom_range(4, 24);
            end
         end
      endcase
   end

   always @(posedge clock) begin : check_tokens
      res_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (expected_tokens.size() == 0) begin
            report_mismatch("token with none expected", 64'(rsp_tuser), '0);
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_tuser !== want.kind)
               report_mismatch("token_kind", 64'(rsp_tuser), 64'(want.kind));
            if (rsp_tdata[31:0] !== want.span_start)
               report_mismatch("span_start", 64'(rsp_tdata[31:0]), 64'(want.span_start));
            if (rsp_tdata[63:32] !== want.span_end)
               report_mismatch("span_end", 64'(rsp_tdata[63:32]), 64'(want.span_end));
            if (rsp_tdata[127:64] !== want.value)
               report_mismatch("number_value", rsp_tdata[127:64], want.value);
            if (rsp_tdata[129:128] !== want.err)
               report_mismatch("error_code", 64'(rsp_tdata[129:128]), 64'(want.err));
            if (rsp_tdata[135:130] !== '0)
               report_mismatch("tdata padding", 64'(rsp_tdata[135:130]), '0);
            if (rsp_tlast !== want.last)
               report_mismatch("last", 64'(rsp_tlast), 64'(want.last));
         end
      end
   end

   // Ends the run when neither side has moved for too long.
   always @(posedge clock) begin : watchdog
      if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
         $display("assembler_source_tokenizer_tb NOT OK");
         $finish;
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      clear_scanner();
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_bad_bytes();
      test_number_limits();
      test_random_full_rate();
      test_random_idling();
      test_random_backpressure();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_tokens.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0)
         $display("assembler_source_tokenizer_tb OK");
      else
         $display("assembler_source_tokenizer_tb NOT OK");
      $finish;
   end

endmodule
